@@ rtl/prc_pkg.sv @@
// Shared types and constants for the packet receive checker.
// No dependencies; imported by every module of the block.
package prc_pkg;

    // Configuration register indexes
    localparam logic [1:0] CFG_MAX_PAYLOAD = 2'd0;
    localparam logic [1:0] CFG_RETRY_LIMIT = 2'd1;

    // Reset values of the configuration registers
    localparam logic [11:0] MAX_PAYLOAD_RST = 12'd2048;
    localparam logic [2:0]  RETRY_LIMIT_RST = 3'd3;

    // Reply bytes and packet types
    localparam logic [7:0] BYTE_ACK  = 8'h06;
    localparam logic [7:0] BYTE_NAK  = 8'h15;
    localparam logic [7:0] TYPE_DATA = 8'h02;

    // Header length in bytes, minus one
    localparam logic [15:0] HDR_LAST = 16'd3;

    // Verdict status codes
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_BADSUM  = 3'd1;
    localparam logic [2:0] ST_TOOLONG = 3'd2;
    localparam logic [2:0] ST_TIMEOUT = 3'd3;
    localparam logic [2:0] ST_GAVEUP  = 3'd4;

    // Result kinds
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    // Queue between front and back
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Classified transaction passed from front to back
    typedef struct packed {
        logic        kind;
        logic [7:0]  data;
        logic [2:0]  code;
        logic        last;
        logic [15:0] plen;
    } t_entry;

endpackage

@@ rtl/packet_receive_checker.sv @@
// Packet receive checker: length-prefixed packets with additive checksum.
// Uses prc_pkg, prc_front, prc_queue and prc_back.
//
// Input channel (i_in_valid / o_in_ready): one transaction per serial byte
// (i_cmd = 0) or per read timeout tick (i_cmd = 1). Output channel
// (o_out_valid / i_out_ready): payload bytes as they arrive and one verdict
// per packet, with the reply byte, if any, to send back to the partner.
// Config channel (i_cfg_valid / o_cfg_ready): index 0 max_payload, index 1
// retry_limit; write only while the block is idle.
// Throughput: one input transaction per cycle while the queue has room, set
// by the parser update in the front end. Each result passes through a queue
// entry, then the output register.
// Reset clears the parser to the header phase, empties the queue, zeroes
// the retry count and restores the config defaults.
// When the receiver stalls, the output register holds and the four-entry
// queue fills; o_in_ready drops only when the queue is full.
module packet_receive_checker
    import prc_pkg::*;
#(
    parameter int BUFFER_BYTES = 2048
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_cmd,
    input  logic [7:0]  i_rx_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_kind,
    output logic [7:0]  o_data_byte,
    output logic [2:0]  o_status,
    output logic        o_reply_valid,
    output logic [7:0]  o_reply_byte,
    output logic        o_last_packet,
    output logic [15:0] o_payload_length,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [11:0] i_cfg_data
);

    logic [11:0] r_max_payload;
    logic [2:0]  r_retry_limit;
    logic [15:0] cap;
    logic        in_accept;
    logic        push, pop, q_not_full, q_valid;
    t_entry      push_entry, q_entry;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = q_not_full;
    assign in_accept   = i_in_valid && q_not_full;
    assign cap = ({4'd0, r_max_payload} < 16'(BUFFER_BYTES)) ? {4'd0, r_max_payload}
                                                             : 16'(BUFFER_BYTES);

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_payload <= MAX_PAYLOAD_RST;
            r_retry_limit <= RETRY_LIMIT_RST;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_MAX_PAYLOAD) begin
                r_max_payload <= i_cfg_data;
            end else if (i_cfg_index == CFG_RETRY_LIMIT) begin
                r_retry_limit <= i_cfg_data[2:0];
            end
        end
    end

    prc_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (in_accept),
        .i_cmd     (i_cmd),
        .i_rx_byte (i_rx_byte),
        .i_cap     (cap),
        .o_push    (push),
        .o_entry   (push_entry)
    );

    prc_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_entry    (push_entry),
        .i_pop      (pop),
        .o_not_full (q_not_full),
        .o_valid    (q_valid),
        .o_entry    (q_entry)
    );

    prc_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_retry_limit    (r_retry_limit),
        .i_q_valid        (q_valid),
        .i_entry          (q_entry),
        .o_pop            (pop),
        .o_valid          (o_out_valid),
        .i_ready          (i_out_ready),
        .o_kind           (o_kind),
        .o_data_byte      (o_data_byte),
        .o_status         (o_status),
        .o_reply_valid    (o_reply_valid),
        .o_reply_byte     (o_reply_byte),
        .o_last_packet    (o_last_packet),
        .o_payload_length (o_payload_length)
    );

    // A payload result carries no status and no reply
    a_payload_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_kind == KIND_PAYLOAD) |-> (o_status == ST_OK) && !o_reply_valid)
        else $error("payload result with status or reply");

    // Giving up never sends a reply
    a_gaveup_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == ST_GAVEUP) |-> !o_reply_valid)
        else $error("gave-up verdict with reply");

    // ACK goes with success, NAK with a failure
    a_reply_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_reply_valid |->
            ((o_status == ST_OK) == (o_reply_byte == BYTE_ACK)))
        else $error("reply byte does not match status");

    // A queued entry reaches a free output register in the next cycle
    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_valid && (!o_out_valid || i_out_ready) |=> o_out_valid)
        else $error("queued entry not moved to output");

endmodule

@@ rtl/prc_front.sv @@
// Front end: parses header, payload and footer and classifies each byte.
// Depends on prc_pkg; pushes t_entry records into prc_queue.
module prc_front
    import prc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_accept,
    input  logic        i_cmd,
    input  logic [7:0]  i_rx_byte,
    input  logic [15:0] i_cap,
    output logic        o_push,
    output t_entry      o_entry
);

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_PAYLOAD,
        PH_FOOTER
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [15:0] r_count, n_count;
    logic [7:0]  r_type, n_type;
    logic [15:0] r_len, n_len;
    logic [15:0] r_sum, n_sum;
    logic [7:0]  r_flow, n_flow;
    logic [15:0] cnt_inc;
    logic [15:0] footer;

    assign cnt_inc = r_count + 16'd1;
    assign footer  = {i_rx_byte, r_flow};

    // Parse the accepted transaction and build its result record
    always_comb begin
        n_phase = r_phase;
        n_count = r_count;
        n_type  = r_type;
        n_len   = r_len;
        n_sum   = r_sum;
        n_flow  = r_flow;
        o_push  = 1'b0;
        o_entry = '{kind: KIND_PAYLOAD, data: 8'd0, code: ST_OK, last: 1'b0, plen: 16'd0};
        if (i_accept) begin
            if (i_cmd) begin
                // timeout tick: fail the packet and restart
                o_push       = 1'b1;
                o_entry.kind = KIND_VERDICT;
                o_entry.code = ST_TIMEOUT;
                n_phase      = PH_HEADER;
                n_count      = 16'd0;
                n_sum        = 16'd0;
            end else begin
                case (r_phase)
                    PH_HEADER: begin
                        if (r_count == 16'd0) begin
                            n_type = i_rx_byte;
                        end else if (r_count == 16'd2) begin
                            n_len = {8'd0, i_rx_byte};
                        end else if (r_count == HDR_LAST) begin
                            n_len = {i_rx_byte, r_len[7:0]};
                        end
                        if (r_count >= HDR_LAST) begin
                            n_count = 16'd0;
                            n_sum   = 16'd0;
                            n_phase = (n_len == 16'd0) ? PH_FOOTER : PH_PAYLOAD;
                        end else begin
                            n_count = cnt_inc;
                        end
                    end
                    PH_PAYLOAD: begin
                        n_sum   = r_sum + {8'd0, i_rx_byte};
                        n_count = cnt_inc;
                        if (cnt_inc >= r_len) begin
                            n_count = 16'd0;
                            n_phase = PH_FOOTER;
                        end
                        o_push       = 1'b1;
                        o_entry.data = i_rx_byte;
                    end
                    PH_FOOTER: begin
                        if (r_count == 16'd0) begin
                            n_flow  = i_rx_byte;
                            n_count = 16'd1;
                        end else begin
                            o_push       = 1'b1;
                            o_entry.kind = KIND_VERDICT;
                            o_entry.last = (r_type != TYPE_DATA);
                            o_entry.plen = r_len;
                            if (r_len > i_cap) begin
                                o_entry.code = ST_TOOLONG;
                            end else if (footer != r_sum) begin
                                o_entry.code = ST_BADSUM;
                            end else begin
                                o_entry.code = ST_OK;
                            end
                            n_phase = PH_HEADER;
                            n_count = 16'd0;
                            n_sum   = 16'd0;
                        end
                    end
                    default: begin
                        n_phase = PH_HEADER;
                        n_count = 16'd0;
                        n_sum   = 16'd0;
                    end
                endcase
            end
        end
    end

    // Hold parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEADER;
            r_count <= 16'd0;
            r_type  <= 8'd0;
            r_len   <= 16'd0;
            r_sum   <= 16'd0;
            r_flow  <= 8'd0;
        end else begin
            r_phase <= n_phase;
            r_count <= n_count;
            r_type  <= n_type;
            r_len   <= n_len;
            r_sum   <= n_sum;
            r_flow  <= n_flow;
        end
    end

endmodule

@@ rtl/prc_queue.sv @@
// Short FIFO of classified transactions between front and back.
// Depends on prc_pkg for t_entry and the queue depth.
module prc_queue
    import prc_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_entry,
    input  logic   i_pop,
    output logic   o_not_full,
    output logic   o_valid,
    output t_entry o_entry
);

    t_entry              r_mem [QDEPTH];
    logic [QPTR_W-1:0]   r_wptr, r_rptr;
    logic [QCNT_W-1:0]   r_count;
    logic                do_pop;

    assign o_not_full = (r_count < QCNT_W'(QDEPTH));
    assign o_valid    = (r_count != '0);
    assign o_entry    = r_mem[r_rptr];
    assign do_pop     = i_pop && o_valid;

    // Store pushed entries
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_entry;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            r_count <= r_count + QCNT_W'(i_push) - QCNT_W'(do_pop);
        end
    end

endmodule

@@ rtl/prc_back.sv @@
// Back end: applies the retry policy and drives the registered result.
// Depends on prc_pkg; pops t_entry records from prc_queue.
module prc_back
    import prc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [2:0]  i_retry_limit,
    input  logic        i_q_valid,
    input  t_entry      i_entry,
    output logic        o_pop,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_kind,
    output logic [7:0]  o_data_byte,
    output logic [2:0]  o_status,
    output logic        o_reply_valid,
    output logic [7:0]  o_reply_byte,
    output logic        o_last_packet,
    output logic [15:0] o_payload_length
);

    logic        r_valid;
    logic [2:0]  r_retry, n_retry;
    logic [2:0]  n_status;
    logic        n_rvalid;
    logic [7:0]  n_rbyte;
    logic        load;

    assign load  = !r_valid || i_ready;
    assign o_pop = load && i_q_valid;

    // Resolve verdicts against the retry count
    always_comb begin
        n_retry  = r_retry;
        n_status = ST_OK;
        n_rvalid = 1'b0;
        n_rbyte  = 8'd0;
        if (i_entry.kind == KIND_VERDICT) begin
            if (i_entry.code == ST_OK) begin
                n_retry  = 3'd0;
                n_rvalid = 1'b1;
                n_rbyte  = BYTE_ACK;
            end else if (r_retry < i_retry_limit) begin
                n_retry  = r_retry + 3'd1;
                n_status = i_entry.code;
                n_rvalid = 1'b1;
                n_rbyte  = BYTE_NAK;
            end else begin
                n_retry  = 3'd0;
                n_status = ST_GAVEUP;
            end
        end
    end

    // Hold valid and retry count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_retry <= 3'd0;
        end else begin
            if (load) begin
                r_valid <= i_q_valid;
            end
            if (o_pop) begin
                r_retry <= n_retry;
            end
        end
    end

    // Load the output register
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            o_kind           <= i_entry.kind;
            o_data_byte      <= i_entry.data;
            o_status         <= n_status;
            o_reply_valid    <= n_rvalid;
            o_reply_byte     <= n_rbyte;
            o_last_packet    <= i_entry.last;
            o_payload_length <= i_entry.plen;
        end
    end

    assign o_valid = r_valid;

endmodule

@@ test/tb.sv @@
// Testbench for packet_receive_checker: serial packets, timeout ticks and register
// writes under random gaps and receiver stalls, checked against an in-bench predictor.
// Depends on prc_pkg and the packet_receive_checker RTL.
module tb
    import prc_pkg::*;
();

    localparam int          HALF_PERIOD   = 5;
    localparam int          BUFFER_BYTES  = 2048;
    localparam int unsigned LIMIT_CYCLES  = 1_000_000;
    localparam int          SETTLE_CYCLES = 8;
    localparam int          RANDOM_ITEMS  = 1060;
    localparam int          MAX_REPORTS   = 10;
    localparam logic        CMD_BYTE      = 1'b0;
    localparam logic        CMD_TICK      = 1'b1;
    localparam logic [7:0]  TYPE_LAST     = 8'h03;
    localparam logic [1:0]  CFG_UNUSED    = 2'd2;

    typedef enum logic [1:0] {SEC_HEADER, SEC_PAYLOAD, SEC_FOOTER} t_section;
    typedef enum logic [1:0] {FAULT_NONE, FAULT_SUM, FAULT_TICK} t_packet_fault;

    typedef struct packed {
        logic        kind;
        logic [7:0]  data;
        logic [2:0]  status;
        logic        reply_valid;
        logic [7:0]  reply_byte;
        logic        last;
        logic [15:0] plen;
    } t_rx_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic        i_cmd;
    logic [7:0]  i_rx_byte;
    logic        o_out_valid;
    logic        i_out_ready;
    logic        o_kind;
    logic [7:0]  o_data_byte;
    logic [2:0]  o_status;
    logic        o_reply_valid;
    logic [7:0]  o_reply_byte;
    logic        o_last_packet;
    logic [15:0] o_payload_length;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [11:0] i_cfg_data;

    packet_receive_checker #(.BUFFER_BYTES(BUFFER_BYTES)) dut (.*);

    // Predicted parser state and register copies
    logic [11:0] cfg_max_payload = MAX_PAYLOAD_RST;
    logic [2:0]  cfg_retry_limit = RETRY_LIMIT_RST;
    t_section    section         = SEC_HEADER;
    logic [15:0] sec_count       = '0;
    logic [7:0]  pkt_type        = '0;
    logic [15:0] pkt_len         = '0;
    logic [15:0] payload_sum     = '0;
    logic [7:0]  footer_lo       = '0;
    logic [2:0]  retries         = '0;

    t_rx_result  predicted_results[$];
    int unsigned items_sent    = 0;
    int unsigned failures      = 0;
    int unsigned cycle_count   = 0;
    int unsigned burst_left    = 0;
    bit          gaps_on       = 1'b1;
    logic [15:0] stall_pattern = 16'hFFFF;
    int unsigned stall_left    = 0;

    // Free-running clock
    initial i_clk = 1'b0;
    always #HALF_PERIOD i_clk = ~i_clk;

    // Close out a packet: apply retry accounting and queue the verdict
    task automatic push_verdict(input logic [2:0] code, input logic last,
                                input logic [15:0] plen);
        t_rx_result r;
        r = '{kind: KIND_VERDICT, data: 8'h00, status: code, reply_valid: 1'b1,
              reply_byte: BYTE_ACK, last: last, plen: plen};
        if (code == ST_OK) begin
            retries = '0;
        end else if (retries < cfg_retry_limit) begin
            retries = retries + 3'd1;
            r.reply_byte = BYTE_NAK;
        end else begin
            retries = '0;
            r.status = ST_GAVEUP;
            r.reply_valid = 1'b0;
            r.reply_byte = 8'h00;
        end
        predicted_results.push_back(r);
        section = SEC_HEADER;
        sec_count = '0;
        payload_sum = '0;
    endtask

    // Advance the predicted parser by one accepted input transaction
    task automatic parse_rx_item(input logic cmd, input logic [7:0] b);
        logic [15:0] cap;
        logic [15:0] footer;
        logic [2:0]  code;
        if (cmd == CMD_TICK) begin
            push_verdict(ST_TIMEOUT, 1'b0, 16'd0);
            return;
        end
        case (section)
            SEC_HEADER: begin
                if (sec_count == 16'd0)
                    pkt_type = b;
                else if (sec_count == 16'd2)
                    pkt_len = {8'h00, b};
                else if (sec_count == HDR_LAST)
                    pkt_len[15:8] = b;
                if (sec_count >= HDR_LAST) begin
                    sec_count = '0;
                    payload_sum = '0;
                    section = (pkt_len == 16'd0) ? SEC_FOOTER : SEC_PAYLOAD;
                end else begin
                    sec_count = sec_count + 16'd1;
                end
            end
            SEC_PAYLOAD: begin
                payload_sum = payload_sum + {8'h00, b};
                sec_count = sec_count + 16'd1;
                if (sec_count >= pkt_len) begin
                    sec_count = '0;
                    section = SEC_FOOTER;
                end
                predicted_results.push_back('{kind: KIND_PAYLOAD, data: b, status: ST_OK,
                    reply_valid: 1'b0, reply_byte: 8'h00, last: 1'b0, plen: 16'd0});
            end
            SEC_FOOTER: begin
                if (sec_count == 16'd0) begin
                    footer_lo = b;
                    sec_count = 16'd1;
                end else begin
                    cap = ({4'h0, cfg_max_payload} < 16'(BUFFER_BYTES)) ?
                          {4'h0, cfg_max_payload} : 16'(BUFFER_BYTES);
                    footer = {b, footer_lo};
                    if (pkt_len > cap)
                        code = ST_TOOLONG;
                    else if (footer != payload_sum)
                        code = ST_BADSUM;
                    else
                        code = ST_OK;
                    push_verdict(code, pkt_type != TYPE_DATA, pkt_len);
                end
            end
            default: begin
                section = SEC_HEADER;
                sec_count = '0;
                payload_sum = '0;
            end
        endcase
    endtask

    // Send one input transaction, in bursts with random gaps between them
    task automatic send_item(input logic cmd, input logic [7:0] b);
        int unsigned gap;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if (gaps_on)
                gap = $urandom_range(1, 6);
        end
        burst_left--;
        @(negedge i_clk);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_cmd      <= cmd;
        i_rx_byte  <= b;
        do @(posedge i_clk); while (!o_in_ready);
        parse_rx_item(cmd, b);
        items_sent++;
    endtask

    task automatic send_header(input logic [7:0] ptype, input logic [7:0] seq,
                               input logic [15:0] len);
        send_item(CMD_BYTE, ptype);
        send_item(CMD_BYTE, seq);
        send_item(CMD_BYTE, len[7:0]);
        send_item(CMD_BYTE, len[15:8]);
    endtask

    task automatic send_footer(input logic [15:0] footer);
        send_item(CMD_BYTE, footer[7:0]);
        send_item(CMD_BYTE, footer[15:8]);
    endtask

    // Send a whole packet with random payload; optionally corrupt or cut it
    task automatic send_packet(input logic [7:0] ptype, input logic [15:0] len,
                               input t_packet_fault fault);
        logic [15:0] sum;
        logic [15:0] footer;
        logic [7:0]  b;
        int          total;
        int          cut;
        total  = 6 + int'(len);
        cut    = (fault == FAULT_TICK) ? int'($urandom_range(0, total - 1)) : total;
        sum    = '0;
        footer = '0;
        for (int pos = 0; pos < total; pos++) begin
            if (pos == cut) begin
                send_item(CMD_TICK, 8'($urandom));
                return;
            end
            if (pos == 0) begin
                b = ptype;
            end else if (pos == 1) begin
                b = 8'($urandom);
            end else if (pos == 2) begin
                b = len[7:0];
            end else if (pos == 3) begin
                b = len[15:8];
            end else if (pos < 4 + int'(len)) begin
                b = 8'($urandom);
                sum = sum + {8'h00, b};
            end else if (pos == 4 + int'(len)) begin
                footer = sum;
                if (fault == FAULT_SUM)
                    footer = footer ^ 16'($urandom_range(1, 65535));
                b = footer[7:0];
            end else begin
                b = footer[15:8];
            end
            send_item(CMD_BYTE, b);
        end
    endtask

    // Hold the sender until every predicted result is out, then let the block settle
    task automatic wait_for_drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        burst_left = 0;
        while (predicted_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write one register while the block is idle
    task automatic write_config(input logic [1:0] index, input logic [11:0] value);
        wait_for_drain();
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (index == CFG_MAX_PAYLOAD)
            cfg_max_payload = value;
        else if (index == CFG_RETRY_LIMIT)
            cfg_retry_limit = value[2:0];
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Receiver: rotate a ready pattern, switching it every so often
    always @(negedge i_clk) begin
        if (stall_left == 0) begin
            stall_left = $urandom_range(16, 160);
            case ($urandom_range(0, 3))
                0: stall_pattern = 16'hFFFF;
                1: stall_pattern = 16'($urandom) | 16'h0001;
                2: stall_pattern = (16'($urandom) & 16'($urandom)) | 16'h0001;
                default: stall_pattern = 16'h8000;
            endcase
        end
        stall_left--;
        stall_pattern = {stall_pattern[14:0], stall_pattern[15]};
        i_out_ready <= stall_pattern[15];
    end

    // Check each result transaction against the oldest prediction
    always @(posedge i_clk) begin : check_results
        t_rx_result got;
        t_rx_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got = '{kind: o_kind, data: o_data_byte, status: o_status,
                    reply_valid: o_reply_valid, reply_byte: o_reply_byte,
                    last: o_last_packet, plen: o_payload_length};
            if (predicted_results.size() == 0) begin
                failures++;
                if (failures <= MAX_REPORTS) begin
                    $write("unexpected result: kind=%0d data=%02h status=%0d ",
                           got.kind, got.data, got.status);
                    $display("reply=%0d/%02h last=%0d len=%0d",
                             got.reply_valid, got.reply_byte, got.last, got.plen);
                end
            end else begin
                want = predicted_results.pop_front();
                if (got.kind !== want.kind || got.data !== want.data ||
                    got.status !== want.status || got.reply_valid !== want.reply_valid ||
                    got.reply_byte !== want.reply_byte || got.last !== want.last ||
                    got.plen !== want.plen) begin
                    failures++;
                    if (failures <= MAX_REPORTS) begin
                        $write("mismatch: expected kind=%0d data=%02h status=%0d ",
                               want.kind, want.data, want.status);
                        $write("reply=%0d/%02h last=%0d len=%0d, ",
                               want.reply_valid, want.reply_byte, want.last, want.plen);
                        $write("got kind=%0d data=%02h status=%0d ",
                               got.kind, got.data, got.status);
                        $display("reply=%0d/%02h last=%0d len=%0d",
                                 got.reply_valid, got.reply_byte, got.last, got.plen);
                    end
                end
            end
        end
    end

    // Stop a hung run
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("** packet_receive_checker: FAILED **");
            $finish;
        end
    end

    // Default registers: ticks, good and bad packets, zero length, cut payload
    task automatic test_directed();
        send_item(CMD_TICK, 8'hA5);                 // tick before any header byte
        send_header(TYPE_DATA, 8'hFF, 16'd2);
        send_item(CMD_BYTE, 8'hFF);
        send_item(CMD_BYTE, 8'h00);
        send_footer(16'h00FF);
        send_header(TYPE_LAST, 8'h00, 16'd0);       // straight to footer
        send_footer(16'h0000);
        send_header(8'h80, 8'h55, 16'd1);           // only the high footer byte is wrong
        send_item(CMD_BYTE, 8'h80);
        send_footer(16'h0180);
        send_header(TYPE_DATA, 8'h00, 16'hFFFF);    // longest length, cut by a tick
        send_item(CMD_TICK, 8'h5A);
    endtask

    // Retry accounting at both ends of the limit, and a limit below the count
    task automatic test_retry_limit();
        write_config(CFG_RETRY_LIMIT, 12'd0);
        send_item(CMD_TICK, 8'h00);
        send_item(CMD_TICK, 8'hFF);
        write_config(CFG_RETRY_LIMIT, 12'd7);
        repeat (8) send_item(CMD_TICK, 8'($urandom));
        repeat (5) send_item(CMD_TICK, 8'($urandom));
        write_config(CFG_RETRY_LIMIT, 12'd2);
        send_item(CMD_TICK, 8'($urandom));
        write_config(CFG_RETRY_LIMIT, 12'(RETRY_LIMIT_RST));
        send_item(CMD_TICK, 8'($urandom));
        send_packet(TYPE_DATA, 16'd3, FAULT_NONE);
        send_packet(TYPE_DATA, 16'd3, FAULT_SUM);
    endtask

    // Capacity checks and too long ahead of a bad checksum
    task automatic test_payload_limit();
        write_config(CFG_MAX_PAYLOAD, 12'd0);
        send_packet(TYPE_DATA, 16'd0, FAULT_NONE);
        send_packet(TYPE_DATA, 16'd1, FAULT_NONE);
        send_packet(TYPE_LAST, 16'd2, FAULT_SUM);
        write_config(CFG_UNUSED, 12'hFFF);
        send_packet(TYPE_DATA, 16'd1, FAULT_NONE);
        write_config(CFG_MAX_PAYLOAD, 12'd17);
        send_packet(TYPE_DATA, 16'd17, FAULT_NONE);
        send_packet(TYPE_DATA, 16'd18, FAULT_NONE);
        write_config(CFG_MAX_PAYLOAD, MAX_PAYLOAD_RST);
    endtask

    // Mostly well-formed packets with random content, plus resync noise
    task automatic test_random_traffic();
        int unsigned goal;
        int unsigned next_cfg;
        int unsigned pick;
        int unsigned noise_len;
        logic [15:0] len;
        logic [7:0]  ptype;
        logic [11:0] limit_value;
        t_packet_fault fault;
        goal = items_sent + RANDOM_ITEMS;
        next_cfg = items_sent + 150;
        while (items_sent < goal) begin
            // Reprogram both registers between packets now and then
            if (items_sent >= next_cfg) begin
                next_cfg = items_sent + $urandom_range(100, 250);
                gaps_on = ($urandom_range(0, 2) != 0);
                case ($urandom_range(0, 3))
                    0: limit_value = 12'd0;
                    1: limit_value = MAX_PAYLOAD_RST;
                    2: limit_value = 12'($urandom_range(1, 40));
                    default: limit_value = 12'($urandom_range(0, BUFFER_BYTES));
                endcase
                write_config(CFG_MAX_PAYLOAD, limit_value);
                write_config(CFG_RETRY_LIMIT, 12'($urandom_range(0, 7)));
            end
            pick = $urandom_range(0, 99);
            if (pick < 90) begin
                case ($urandom_range(0, 3))
                    0, 1: ptype = TYPE_DATA;
                    2: ptype = TYPE_LAST;
                    default: ptype = 8'($urandom);
                endcase
                pick = $urandom_range(0, 99);
                if (pick < 70)
                    len = 16'($urandom_range(1, 24));
                else if (pick < 85)
                    len = 16'd0;
                else
                    len = 16'($urandom_range(25, 96));
                pick = $urandom_range(0, 99);
                fault = (pick < 80) ? FAULT_NONE : (pick < 92) ? FAULT_SUM : FAULT_TICK;
                send_packet(ptype, len, fault);
            end else begin
                // Garbage bytes, then a tick to bring the parser back to a header
                noise_len = $urandom_range(1, 6);
                repeat (noise_len) send_item(CMD_BYTE, 8'($urandom));
                send_item(CMD_TICK, 8'($urandom));
            end
        end
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_cmd       = CMD_BYTE;
        i_rx_byte   = 8'h00;
        i_out_ready = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_MAX_PAYLOAD;
        i_cfg_data  = 12'h000;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_retry_limit();
        test_payload_limit();
        test_random_traffic();
        wait_for_drain();

        if (failures == 0)
            $display("** packet_receive_checker: PASSED **");
        else
            $display("** packet_receive_checker: FAILED **");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/prc_pkg.sv
rtl/prc_front.sv
rtl/prc_queue.sv
rtl/prc_back.sv
rtl/packet_receive_checker.sv
test/tb.sv
